### hdl/can_pkg.sv
// Shared types and constants for the class-aware NMS block.
// Used by can_ctrl, can_dp and class_aware_nms_top; depends on nothing.
`timescale 1ns / 1ps

package can_pkg;

   localparam int DATA_W     = 80;   // x, y, w, h, score
   localparam int REQ_USER_W = 8;    // class
   localparam int RSP_USER_W = 9;    // class, overflow
   localparam logic [15:0] THR_RESET = 16'd29491;

   // One stored detection, with its suppression mark.
   typedef struct packed {
      logic        sup;
      logic [15:0] score;
      logic [7:0]  cls;
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] y;
      logic [15:0] x;
   } rec_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_SHIFT = 2'd1,
      WR_NEW   = 2'd2,
      WR_SUP   = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       load_new;
      logic       rd_en;
      wr_sel_type wr_sel;
      logic       load_anchor;
      logic       hold_load;
      logic       out_load;
      logic       out_last;
      logic       overflow;
   } cmd_type;

   typedef struct packed {
      logic rd_lt_new;
      logic rd_sup;
      logic cls_eq;
      logic hit;
      logic out_free;
   } status_type;

endpackage

### hdl/class_aware_nms_top.sv
// Top level of the class-aware greedy non-maximum suppression block.
// Depends on can_pkg, can_ctrl and can_dp.
`timescale 1ns / 1ps

//  channel | direction | payload
//  req     | in        | tdata: x, y, w, h, score; tuser: class; tlast: end of set
//  rsp     | out       | tdata: x, y, w, h, score; tuser: class, overflow; tlast: last kept
//  csr     | in        | csr_wr_data: IoU threshold, Q0.16
//
// Each detection is inserted into a store kept sorted by descending score, each entry of
// lower score moving one row down; no new word is taken until the insertion is done.
// After the last word, every live anchor is tested against each later live box of its class.
// A same-class pair runs through the overlap pipeline in states P1 to P4 and any other pair
// skips them; an emit pass then follows, which can stall on the result side.
// Reset is synchronous and active high; the threshold returns to 0.45 (29491).
// A finished result waits in the output register while the block takes new words.

module class_aware_nms_top #(
   parameter int MAX_DETS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0 up: x[15:0], y[31:16], w[47:32], h[63:48], score[79:64].
   input  logic [can_pkg::DATA_W-1:0]      req_tdata,
   // Fields from bit 0 up: class[7:0].
   input  logic [can_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0 up: x[15:0], y[31:16], w[47:32], h[63:48], score[79:64].
   output logic [can_pkg::DATA_W-1:0]      rsp_tdata,
   // Fields from bit 0 up: class[7:0], overflow[8].
   output logic [can_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data
);

   can_pkg::cmd_type              cmd;
   can_pkg::status_type           status;
   logic [$clog2(MAX_DETS)-1:0]   rd_addr;
   logic [$clog2(MAX_DETS)-1:0]   wr_addr;

   // The controller owns the loop counters and the set bookkeeping.
   can_ctrl #(
      .MAX_DETS (MAX_DETS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   // The datapath holds the store, the overlap arithmetic and the result register.
   can_dp #(
      .MAX_DETS (MAX_DETS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### hdl/can_ctrl.sv
// Sequencer for the NMS block: insertion, pairwise suppression and emit passes.
// Depends on can_pkg; drives can_dp through command and address signals.
`timescale 1ns / 1ps

module can_ctrl #(
   parameter int MAX_DETS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tlast,
   output logic                          req_tready,
   input  can_pkg::status_type           status,
   output can_pkg::cmd_type              cmd,
   output logic [$clog2(MAX_DETS)-1:0]   rd_addr,
   output logic [$clog2(MAX_DETS)-1:0]   wr_addr
);

   localparam int IW = $clog2(MAX_DETS);
   localparam int CW = $clog2(MAX_DETS + 1);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_INS_CHK = 14'b00000000000010,
      ST_INS_CMP = 14'b00000000000100,
      ST_N_OUT   = 14'b00000000001000,
      ST_N_ANC   = 14'b00000000010000,
      ST_N_IN    = 14'b00000000100000,
      ST_N_CHK   = 14'b00000001000000,
      ST_P1      = 14'b00000010000000,
      ST_P2      = 14'b00000100000000,
      ST_P3      = 14'b00001000000000,
      ST_P4      = 14'b00010000000000,
      ST_E_RD    = 14'b00100000000000,
      ST_E_CHK   = 14'b01000000000000,
      ST_E_FIN   = 14'b10000000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic            last_ff, last_in;
   logic            dropped_ff, dropped_in;
   logic            held_ff, held_in;
   logic [CW-1:0]   j_dec;

   assign j_dec      = j_ff - CW'(1);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      last_in    = last_ff;
      dropped_in = dropped_ff;
      held_in    = held_ff;
      cmd        = '0;
      cmd.wr_sel = can_pkg::WR_NONE;
      cmd.overflow = dropped_ff;
      rd_addr    = '0;
      wr_addr    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in = req_tlast;
               if (count_ff < CW'(MAX_DETS)) begin
                  cmd.load_new = 1'b1;
                  j_in         = count_ff;
                  state_in     = ST_INS_CHK;
               end else begin
                  dropped_in = 1'b1;
                  if (req_tlast) begin
                     i_in     = '0;
                     state_in = ST_N_OUT;
                  end
               end
            end
         end
         ST_INS_CHK: begin
            if (j_ff == '0) begin
               cmd.wr_sel = can_pkg::WR_NEW;
               wr_addr    = '0;
               count_in   = count_ff + CW'(1);
               i_in       = '0;
               state_in   = last_ff ? ST_N_OUT : ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = j_dec[IW-1:0];
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_addr = j_ff[IW-1:0];
            if (status.rd_lt_new) begin
               cmd.wr_sel = can_pkg::WR_SHIFT;
               j_in       = j_dec;
               state_in   = ST_INS_CHK;
            end else begin
               cmd.wr_sel = can_pkg::WR_NEW;
               count_in   = count_ff + CW'(1);
               i_in       = '0;
               state_in   = last_ff ? ST_N_OUT : ST_IDLE;
            end
         end
         ST_N_OUT: begin
            if (i_ff == count_ff) begin
               i_in     = '0;
               held_in  = 1'b0;
               state_in = ST_E_RD;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = i_ff[IW-1:0];
               state_in  = ST_N_ANC;
            end
         end
         ST_N_ANC: begin
            if (status.rd_sup) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_N_OUT;
            end else begin
               cmd.load_anchor = 1'b1;
               j_in            = i_ff + CW'(1);
               state_in        = ST_N_IN;
            end
         end
         ST_N_IN: begin
            if (j_ff == count_ff) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_N_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = j_ff[IW-1:0];
               state_in  = ST_N_CHK;
            end
         end
         ST_N_CHK: begin
            if (status.rd_sup || !status.cls_eq) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_N_IN;
            end else begin
               state_in = ST_P1;
            end
         end
         ST_P1: state_in = ST_P2;
         ST_P2: state_in = ST_P3;
         ST_P3: state_in = ST_P4;
         ST_P4: begin
            if (status.hit) begin
               cmd.wr_sel = can_pkg::WR_SUP;
               wr_addr    = j_ff[IW-1:0];
            end
            j_in     = j_ff + CW'(1);
            state_in = ST_N_IN;
         end
         ST_E_RD: begin
            if (i_ff == count_ff) begin
               if (held_ff) begin
                  state_in = ST_E_FIN;
               end else begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = i_ff[IW-1:0];
               state_in  = ST_E_CHK;
            end
         end
         ST_E_CHK: begin
            if (status.rd_sup) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_E_RD;
            end else if (!held_ff) begin
               cmd.hold_load = 1'b1;
               held_in       = 1'b1;
               i_in          = i_ff + CW'(1);
               state_in      = ST_E_RD;
            end else if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.hold_load = 1'b1;
               i_in          = i_ff + CW'(1);
               state_in      = ST_E_RD;
            end
         end
         ST_E_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               count_in     = '0;
               dropped_in   = 1'b0;
               held_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         last_ff    <= 1'b0;
         dropped_ff <= 1'b0;
         held_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         last_ff    <= last_in;
         dropped_ff <= dropped_in;
         held_ff    <= held_in;
      end
   end

   // The store never holds more entries than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DETS))
      else $error("entry count beyond capacity");

   // A box is only marked when it is live and of the anchor's class.
   a_sup_class: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_sel == can_pkg::WR_SUP |-> status.cls_eq && !status.rd_sup)
      else $error("suppression of a box of another class or already marked");

   // A shift moves the entry read in the cycle before one row down.
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_sel == can_pkg::WR_SHIFT |-> wr_addr == $past(rd_addr) + IW'(1))
      else $error("insertion shift to the wrong row");

   // The output register is only reloaded once its word has gone.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result overwritten before it was taken");

endmodule

### hdl/can_dp.sv
// Datapath of the NMS block: detection store, IoU pipeline, threshold and output register.
// Depends on can_pkg; steered by can_ctrl.
`timescale 1ns / 1ps

module can_dp #(
   parameter int MAX_DETS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  can_pkg::cmd_type                  cmd,
   input  logic [$clog2(MAX_DETS)-1:0]       rd_addr,
   input  logic [$clog2(MAX_DETS)-1:0]       wr_addr,
   input  logic [can_pkg::DATA_W-1:0]        req_tdata,
   input  logic [can_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              csr_wr_en,
   input  logic [15:0]                       csr_wr_data,
   input  logic                              rsp_tready,
   output can_pkg::status_type               status,
   output logic                              rsp_tvalid,
   output logic [can_pkg::DATA_W-1:0]        rsp_tdata,
   output logic [can_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   can_pkg::rec_type store_mem [MAX_DETS];
   can_pkg::rec_type rd_ff;
   can_pkg::rec_type new_ff;
   can_pkg::rec_type anc_ff;
   can_pkg::rec_type held_ff;
   can_pkg::rec_type out_ff;
   can_pkg::rec_type wr_data;
   logic             wr_en;

   logic [15:0] thr_ff;
   logic [31:0] area_a_ff;
   logic        out_valid_ff;
   logic        out_last_ff;
   logic        out_ovf_ff;

   // Overlap pipeline.
   logic [16:0] a_x2, a_y2, b_x2, b_y2, hi_x, hi_y, dx_full, dy_full;
   logic [15:0] lo_x, lo_y;
   logic        empty_c;
   logic [15:0] dx_ff, dy_ff;
   logic [31:0] area_b_ff;
   logic        empty1_ff, empty2_ff, empty3_ff, empty4_ff;
   logic [31:0] inter2_ff, inter3_ff, inter4_ff;
   logic [32:0] sum2_ff;
   logic [32:0] uni3_ff;
   logic [48:0] prod4_ff;
   logic        uni_zero4_ff;

   always_comb begin
      wr_en   = 1'b1;
      wr_data = rd_ff;
      case (cmd.wr_sel)
         can_pkg::WR_NONE:  wr_en = 1'b0;
         can_pkg::WR_SHIFT: wr_data = rd_ff;
         can_pkg::WR_NEW:   wr_data = new_ff;
         can_pkg::WR_SUP: begin
            wr_data     = rd_ff;
            wr_data.sup = 1'b1;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_new) begin
         new_ff.sup   <= 1'b0;
         new_ff.x     <= req_tdata[15:0];
         new_ff.y     <= req_tdata[31:16];
         new_ff.w     <= req_tdata[47:32];
         new_ff.h     <= req_tdata[63:48];
         new_ff.score <= req_tdata[79:64];
         new_ff.cls   <= req_tuser;
      end
      if (cmd.load_anchor) begin
         anc_ff    <= rd_ff;
         area_a_ff <= rd_ff.w * rd_ff.h;
      end
      if (cmd.hold_load) begin
         held_ff <= rd_ff;
      end
   end

   // Intersection edges; right and bottom edges are 17 bits wide, unclamped.
   always_comb begin
      a_x2    = {1'b0, anc_ff.x} + {1'b0, anc_ff.w};
      a_y2    = {1'b0, anc_ff.y} + {1'b0, anc_ff.h};
      b_x2    = {1'b0, rd_ff.x} + {1'b0, rd_ff.w};
      b_y2    = {1'b0, rd_ff.y} + {1'b0, rd_ff.h};
      lo_x    = (anc_ff.x > rd_ff.x) ? anc_ff.x : rd_ff.x;
      lo_y    = (anc_ff.y > rd_ff.y) ? anc_ff.y : rd_ff.y;
      hi_x    = (a_x2 < b_x2) ? a_x2 : b_x2;
      hi_y    = (a_y2 < b_y2) ? a_y2 : b_y2;
      empty_c = (hi_x <= {1'b0, lo_x}) || (hi_y <= {1'b0, lo_y});
      dx_full = hi_x - {1'b0, lo_x};
      dy_full = hi_y - {1'b0, lo_y};
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_full[15:0];
      dy_ff        <= dy_full[15:0];
      empty1_ff    <= empty_c;
      area_b_ff    <= rd_ff.w * rd_ff.h;
      inter2_ff    <= dx_ff * dy_ff;
      sum2_ff      <= {1'b0, area_a_ff} + {1'b0, area_b_ff};
      empty2_ff    <= empty1_ff;
      uni3_ff      <= sum2_ff - {1'b0, inter2_ff};
      inter3_ff    <= inter2_ff;
      empty3_ff    <= empty2_ff;
      prod4_ff     <= thr_ff * uni3_ff;
      uni_zero4_ff <= (uni3_ff == '0);
      inter4_ff    <= inter3_ff;
      empty4_ff    <= empty3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= can_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff      <= held_ff;
         out_last_ff <= cmd.out_last;
         out_ovf_ff  <= cmd.overflow;
      end
   end

   assign status.rd_lt_new = rd_ff.score < new_ff.score;
   assign status.rd_sup    = rd_ff.sup;
   assign status.cls_eq    = rd_ff.cls == anc_ff.cls;
   assign status.hit       = !empty4_ff && !uni_zero4_ff
                             && ({1'b0, inter4_ff, 16'd0} > prod4_ff);
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.score, out_ff.h, out_ff.w, out_ff.y, out_ff.x};
   assign rsp_tuser  = {out_ovf_ff, out_ff.cls};
   assign rsp_tlast  = out_last_ff;

endmodule
